>>> design/min_tracking_stack_unit_macros.svh
// assertion macros for the min tracking stack unit
// used by the top level only; compiled out when SYNTHESIS is defined
`ifndef MIN_TRACKING_STACK_UNIT_MACROS_SVH
`define MIN_TRACKING_STACK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("min tracking stack: assertion failed");
// next-cycle implication, off during reset
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("min tracking stack: assertion failed");
`else
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/mts_pkg.sv
// shared types and constants for the min tracking stack unit
// used by mts_cell and min_tracking_stack_unit
package mts_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int FILL_W      = 8;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_count;

    localparam t_data MIN_EMPTY = 32'sh7FFF_FFFF;
    localparam t_data TOP_EMPTY = -32'sd1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_POP_EMPTY = 2'd2
    } t_status;

    // shift command shared by every cell of one chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

    // result item as packed on the output tdata, top_value in the low bits
    typedef struct packed {
        logic [4:0]        pad;
        logic [FILL_W-1:0] fill_count;
        t_status           status;
        logic              is_empty;
        t_data             min_value;
        t_data             top_value;
    } t_result;

endpackage

>>> design/mts_cell.sv
// one stack cell: holds one entry and shifts with its neighbors
// depends on mts_pkg
module mts_cell (
    input  logic               i_clk,
    input  mts_pkg::t_cell_ctrl i_ctrl,
    input  mts_pkg::t_data     i_from_above,
    input  mts_pkg::t_data     i_from_below,
    output mts_pkg::t_data     o_value
);

    mts_pkg::t_data r_value;
    mts_pkg::t_data n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.push) begin
            n_value = i_from_above;
        end else if (i_ctrl.pop) begin
            n_value = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> design/min_tracking_stack_unit.sv
// min tracking stack unit: lifo of signed values with running minimum
// output: the result of an accepted item is registered into the output register
// throughput: one item per cycle while results are taken; every item shifts
// both cell chains (values and minima) by at most one place in that cycle
// reset: synchronous; counts and output valid clear; cell contents are not reset
// depends on mts_pkg, mts_cell and min_tracking_stack_unit_macros.svh
`include "min_tracking_stack_unit_macros.svh"

module min_tracking_stack_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // push_value[31:0]
    input  logic        i_s_tuser,   // opcode[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // top_value[31:0], min_value[63:32], is_empty[64],
                                     // status[66:65], fill_count[74:67], zero[79:75]
);

    localparam int DEPTH = mts_pkg::STACK_DEPTH;

    mts_pkg::t_data     w_val [DEPTH];
    mts_pkg::t_data     w_min [DEPTH];
    mts_pkg::t_cell_ctrl w_val_ctrl;
    mts_pkg::t_cell_ctrl w_min_ctrl;

    mts_pkg::t_count  r_val_cnt, n_val_cnt;
    mts_pkg::t_count  r_min_cnt, n_min_cnt;
    logic             r_out_valid;
    mts_pkg::t_result r_out, n_out;

    logic           w_accept;
    logic           w_is_push;
    logic           w_is_pop;
    logic           w_full;
    logic           w_empty;
    logic           w_push_ok;
    logic           w_pop_ok;
    logic           w_min_push;
    logic           w_min_pop;
    mts_pkg::t_data w_push_value;
    mts_pkg::t_data w_cur_min;

    assign o_s_tready   = !r_out_valid || i_m_tready;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_is_push    = (mts_pkg::t_opcode'(i_s_tuser) == mts_pkg::OP_PUSH);
    assign w_is_pop     = (mts_pkg::t_opcode'(i_s_tuser) == mts_pkg::OP_POP);
    assign w_push_value = mts_pkg::t_data'(i_s_tdata);

    assign w_full    = (r_val_cnt == mts_pkg::t_count'(DEPTH));
    assign w_empty   = (r_val_cnt == '0);
    assign w_cur_min = (r_min_cnt == '0) ? mts_pkg::MIN_EMPTY : w_min[0];

    // minima never outnumber values, so a value push always has room for a minimum
    assign w_push_ok  = w_accept && w_is_push && !w_full;
    assign w_pop_ok   = w_accept && w_is_pop && !w_empty;
    assign w_min_push = w_push_ok && (w_cur_min >= w_push_value);
    assign w_min_pop  = w_pop_ok && (w_val[0] == w_cur_min) && (r_min_cnt != '0);

    assign w_val_ctrl = '{push: w_push_ok, pop: w_pop_ok};
    assign w_min_ctrl = '{push: w_min_push, pop: w_min_pop};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cells
            mts_pkg::t_data w_val_above, w_val_below;
            mts_pkg::t_data w_min_above, w_min_below;

            if (gi == 0) begin : g_head
                assign w_val_above = w_push_value;
                assign w_min_above = w_push_value;
            end else begin : g_body
                assign w_val_above = w_val[gi-1];
                assign w_min_above = w_min[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_val_below = '0;
                assign w_min_below = '0;
            end else begin : g_mid
                assign w_val_below = w_val[gi+1];
                assign w_min_below = w_min[gi+1];
            end

            mts_cell u_val_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_val_ctrl),
                .i_from_above (w_val_above),
                .i_from_below (w_val_below),
                .o_value      (w_val[gi])
            );

            mts_cell u_min_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_min_ctrl),
                .i_from_above (w_min_above),
                .i_from_below (w_min_below),
                .o_value      (w_min[gi])
            );
        end
    endgenerate

    always_comb begin
        mts_pkg::t_data top_next;
        mts_pkg::t_data min_next;

        n_val_cnt = r_val_cnt;
        n_min_cnt = r_min_cnt;
        if (w_push_ok) begin
            n_val_cnt = r_val_cnt + mts_pkg::t_count'(1);
        end else if (w_pop_ok) begin
            n_val_cnt = r_val_cnt - mts_pkg::t_count'(1);
        end
        if (w_min_push) begin
            n_min_cnt = r_min_cnt + mts_pkg::t_count'(1);
        end else if (w_min_pop) begin
            n_min_cnt = r_min_cnt - mts_pkg::t_count'(1);
        end

        // what cell 0 of each chain will hold after this item
        if (w_push_ok) begin
            top_next = w_push_value;
        end else if (w_pop_ok) begin
            top_next = w_val[1];
        end else begin
            top_next = w_val[0];
        end
        if (w_min_push) begin
            min_next = w_push_value;
        end else if (w_min_pop) begin
            min_next = w_min[1];
        end else begin
            min_next = w_min[0];
        end

        n_out            = '0;
        n_out.top_value  = (n_val_cnt == '0) ? mts_pkg::TOP_EMPTY : top_next;
        n_out.min_value  = (n_min_cnt == '0) ? mts_pkg::MIN_EMPTY : min_next;
        n_out.is_empty   = (n_val_cnt == '0);
        n_out.fill_count = mts_pkg::FILL_W'(n_val_cnt);
        if (w_is_push && w_full) begin
            n_out.status = mts_pkg::ST_PUSH_FULL;
        end else if (w_is_pop && w_empty) begin
            n_out.status = mts_pkg::ST_POP_EMPTY;
        end else begin
            n_out.status = mts_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_cnt   <= '0;
            r_min_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_val_cnt <= n_val_cnt;
            r_min_cnt <= n_min_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    `MTS_ASSERT_NOW(a_min_cnt_le_val_cnt, i_clk, i_rst_n, 1'b1, r_min_cnt <= r_val_cnt)
    `MTS_ASSERT_NEXT(a_pop_empty_flagged, i_clk, i_rst_n, w_accept && w_is_pop && w_empty, r_out.status == mts_pkg::ST_POP_EMPTY && r_val_cnt == '0)
    `MTS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push_ok, r_val_cnt == $past(r_val_cnt) + mts_pkg::t_count'(1))
    `MTS_ASSERT_NOW(a_min_moves_with_val, i_clk, i_rst_n, w_min_push || w_min_pop, w_push_ok || w_pop_ok)

endmodule
